### hdl/rid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_pkg
// Opcodes, format and instruction codes, control words and the decoded
// result type shared by the instruction decoder modules.
// ----------------------------------------------------------------------------
package rid_pkg;

  localparam logic [6:0] OPC_OP      = 7'b0110011;
  localparam logic [6:0] OPC_OP32    = 7'b0111011;
  localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
  localparam logic [6:0] OPC_OPIMM32 = 7'b0011011;
  localparam logic [6:0] OPC_LOAD    = 7'b0000011;
  localparam logic [6:0] OPC_STORE   = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
  localparam logic [6:0] OPC_JALR    = 7'b1100111;
  localparam logic [6:0] OPC_JAL     = 7'b1101111;
  localparam logic [6:0] OPC_LUI     = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC   = 7'b0010111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  // funct6 forms used by the rv64 shift-immediates
  localparam logic [5:0] F6_BASE = 6'b000000;
  localparam logic [5:0] F6_ALT  = 6'b010000;

  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  // bit0 aluop, 1 regdest, 2 regwrite, 3 alusrc, 4 jump, 5 branch,
  // 6 memread, 7 memwrite, 8 memtoreg
  localparam logic [8:0] CTL_NONE   = 9'h000;
  localparam logic [8:0] CTL_R      = 9'h007;
  localparam logic [8:0] CTL_IARITH = 9'h00F;
  localparam logic [8:0] CTL_LOAD   = 9'h04F;
  localparam logic [8:0] CTL_STORE  = 9'h089;
  localparam logic [8:0] CTL_BRANCH = 9'h021;
  localparam logic [8:0] CTL_JALR   = 9'h01D;
  localparam logic [8:0] CTL_JAL    = 9'h01C;
  localparam logic [8:0] CTL_LUI    = 9'h006;
  localparam logic [8:0] CTL_AUIPC  = 9'h00F;

  typedef enum logic [2:0] {
    FMT_R  = 3'd0,
    FMT_I  = 3'd1,
    FMT_S  = 3'd2,
    FMT_SB = 3'd3,
    FMT_UJ = 3'd4,
    FMT_U  = 3'd5
  } format_t;

  typedef enum logic [5:0] {
    IC_ADD, IC_SUB, IC_MUL, IC_MULH, IC_SLL, IC_MULHSU, IC_SLT, IC_MULHU,
    IC_SLTU, IC_DIV, IC_XOR, IC_OR, IC_REM, IC_AND, IC_REMU, IC_SRL,
    IC_DIVU, IC_SRA,
    IC_ADDW, IC_SUBW, IC_MULW, IC_SLLW, IC_DIVW, IC_SRLW, IC_DIVUW, IC_SRAW,
    IC_REMW, IC_REMUW,
    IC_ADDI, IC_SLTI, IC_SLTIU, IC_XORI, IC_ORI, IC_ANDI, IC_SLLI, IC_SRLI,
    IC_SRAI,
    IC_ADDIW, IC_SLLIW, IC_SRLIW, IC_SRAIW,
    IC_LB, IC_LH, IC_LW, IC_LBU, IC_LHU,
    IC_SB, IC_SH, IC_SW,
    IC_BEQ, IC_BNE, IC_BLT, IC_BGE, IC_BLTU, IC_BGEU,
    IC_JALR, IC_JAL, IC_LUI, IC_AUIPC
  } instr_code_t;

  typedef struct packed {
    logic               illegal;
    format_t            format;
    instr_code_t        instr_code;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [11:0] immediate;
    logic [8:0]         control_lines;
  } rid_result_t;

endpackage
`default_nettype wire

### hdl/riscv_instruction_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// riscv_instruction_decoder
// RV64IM decoder, 59 instructions, input register -> decode -> result register.
// ----------------------------------------------------------------------------
// Takes one 32-bit instruction word per cycle while in_ready is high and
// returns one decoded item per word: format, dense instruction code,
// rd/rs1/rs2 fields, I or S immediate and nine control lines; words outside
// the decoded set come out with illegal set and format, code, immediate and
// controls zero. Throughput is one item per clock while out_ready is high.
// The accepting edge loads the input register; the result register takes
// the decoded item once it has room, which raises out_valid, with the
// opcode/funct3/funct7 lookup in between. Ready flows back combinationally
// through both registers, so the pipe keeps moving while out_ready is high.
module riscv_instruction_decoder import rid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_instr_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_illegal,
  output logic [2:0]       out_format,
  output logic [5:0]       out_instr_code,
  output logic [4:0]       out_dest_reg,
  output logic [4:0]       out_src_reg_a,
  output logic [4:0]       out_src_reg_b,
  output logic signed [11:0] out_immediate,
  output logic [8:0]       out_control_lines
);

  logic        dec_valid;
  logic        dec_ready;
  logic [31:0] dec_word;
  rid_result_t dec_result;
  rid_result_t res;

  rid_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_instr_word (in_instr_word),
    .stage_valid   (dec_valid),
    .stage_ready   (dec_ready),
    .stage_word    (dec_word)
  );

  rid_decode u_decode (
    .instr_word (dec_word),
    .result     (dec_result)
  );

  rid_out_stage u_out_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage_valid  (dec_valid),
    .stage_ready  (dec_ready),
    .stage_result (dec_result),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (res)
  );

  assign out_illegal       = res.illegal;
  assign out_format        = res.format;
  assign out_instr_code    = res.instr_code;
  assign out_dest_reg      = res.dest_reg;
  assign out_src_reg_a     = res.src_reg_a;
  assign out_src_reg_b     = res.src_reg_b;
  assign out_immediate     = res.immediate;
  assign out_control_lines = res.control_lines;

  // an illegal item carries no code, format or controls
  a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |->
      out_control_lines == CTL_NONE && out_format == FMT_R &&
      out_immediate == 12'sd0)
    else $error("illegal item with nonzero decode fields");

  // a full input register that can advance shows up at the output next cycle
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid && dec_ready |=> out_valid)
    else $error("decoded item lost between stages");

  // both registers full and output stalled: no new item may enter
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid && out_valid && !out_ready |-> !in_ready)
    else $error("item accepted while pipe is full");

  // memtoreg is never driven
  a_no_memtoreg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_control_lines[8])
    else $error("memtoreg set");

endmodule
`default_nettype wire

### hdl/rid_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_in_stage
// Input register: captures one instruction word per accepted item and holds
// it until the result register takes the decoded item.
// ----------------------------------------------------------------------------
module rid_in_stage import rid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_instr_word,
  output logic             stage_valid,
  input  wire logic        stage_ready,
  output logic [31:0]      stage_word
);

  logic        valid_r, valid_nxt;
  logic [31:0] word_r;

  assign in_ready = !valid_r || stage_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_instr_word;
    end
  end

  assign stage_valid = valid_r;
  assign stage_word  = word_r;

endmodule
`default_nettype wire

### hdl/rid_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_decode
// Combinational decode of one RV64IM instruction word into format, code,
// register fields, I/S immediate and control lines.
// ----------------------------------------------------------------------------
module rid_decode import rid_pkg::*; (
  input  wire logic [31:0] instr_word,
  output rid_result_t      result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        found;
  instr_code_t code;
  format_t     fmt;
  logic [8:0]  ctl;

  assign opc = instr_word[6:0];
  assign f3  = instr_word[14:12];
  assign f7  = instr_word[31:25];

  always_comb begin
    found = 1'b1;
    code  = IC_ADD;
    case (opc)
      OPC_OP: begin
        case (f3)
          F3_0: begin
            if (f7 == F7_BASE) code = IC_ADD;
            else if (f7 == F7_ALT) code = IC_SUB;
            else if (f7 == F7_MULDIV) code = IC_MUL;
            else found = 1'b0;
          end
          F3_1: begin
            if (f7 == F7_MULDIV) code = IC_MULH;
            else if (f7 == F7_BASE) code = IC_SLL;
            else found = 1'b0;
          end
          F3_2: begin
            if (f7 == F7_MULDIV) code = IC_MULHSU;
            else if (f7 == F7_BASE) code = IC_SLT;
            else found = 1'b0;
          end
          F3_3: begin
            if (f7 == F7_MULDIV) code = IC_MULHU;
            else if (f7 == F7_BASE) code = IC_SLTU;
            else found = 1'b0;
          end
          F3_4: begin
            if (f7 == F7_MULDIV) code = IC_DIV;
            else if (f7 == F7_BASE) code = IC_XOR;
            else found = 1'b0;
          end
          F3_5: begin
            if (f7 == F7_BASE) code = IC_SRL;
            else if (f7 == F7_MULDIV) code = IC_DIVU;
            else if (f7 == F7_ALT) code = IC_SRA;
            else found = 1'b0;
          end
          F3_6: begin
            if (f7 == F7_BASE) code = IC_OR;
            else if (f7 == F7_MULDIV) code = IC_REM;
            else found = 1'b0;
          end
          default: begin
            if (f7 == F7_BASE) code = IC_AND;
            else if (f7 == F7_MULDIV) code = IC_REMU;
            else found = 1'b0;
          end
        endcase
      end
      OPC_OP32: begin
        case (f3)
          F3_0: begin
            if (f7 == F7_BASE) code = IC_ADDW;
            else if (f7 == F7_ALT) code = IC_SUBW;
            else if (f7 == F7_MULDIV) code = IC_MULW;
            else found = 1'b0;
          end
          F3_1: begin
            if (f7 == F7_BASE) code = IC_SLLW;
            else found = 1'b0;
          end
          F3_4: begin
            if (f7 == F7_MULDIV) code = IC_DIVW;
            else found = 1'b0;
          end
          F3_5: begin
            if (f7 == F7_BASE) code = IC_SRLW;
            else if (f7 == F7_MULDIV) code = IC_DIVUW;
            else if (f7 == F7_ALT) code = IC_SRAW;
            else found = 1'b0;
          end
          F3_6: begin
            if (f7 == F7_MULDIV) code = IC_REMW;
            else found = 1'b0;
          end
          F3_7: begin
            if (f7 == F7_MULDIV) code = IC_REMUW;
            else found = 1'b0;
          end
          default: found = 1'b0;
        endcase
      end
      OPC_OPIMM: begin
        case (f3)
          F3_0: code = IC_ADDI;
          F3_2: code = IC_SLTI;
          F3_3: code = IC_SLTIU;
          F3_4: code = IC_XORI;
          F3_6: code = IC_ORI;
          F3_7: code = IC_ANDI;
          // rv64 shift amount reaches bit 25, so only funct6 is checked
          F3_1: begin
            if (f7[6:1] == F6_BASE) code = IC_SLLI;
            else found = 1'b0;
          end
          default: begin
            if (f7[6:1] == F6_BASE) code = IC_SRLI;
            else if (f7[6:1] == F6_ALT) code = IC_SRAI;
            else found = 1'b0;
          end
        endcase
      end
      OPC_OPIMM32: begin
        case (f3)
          F3_0: code = IC_ADDIW;
          F3_1: begin
            if (f7 == F7_BASE) code = IC_SLLIW;
            else found = 1'b0;
          end
          F3_5: begin
            if (f7 == F7_BASE) code = IC_SRLIW;
            else if (f7 == F7_ALT) code = IC_SRAIW;
            else found = 1'b0;
          end
          default: found = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        case (f3)
          F3_0: code = IC_LB;
          F3_1: code = IC_LH;
          F3_2: code = IC_LW;
          F3_4: code = IC_LBU;
          F3_5: code = IC_LHU;
          default: found = 1'b0;
        endcase
      end
      OPC_STORE: begin
        case (f3)
          F3_0: code = IC_SB;
          F3_1: code = IC_SH;
          F3_2: code = IC_SW;
          default: found = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        case (f3)
          F3_0: code = IC_BEQ;
          F3_1: code = IC_BNE;
          F3_4: code = IC_BLT;
          F3_5: code = IC_BGE;
          F3_6: code = IC_BLTU;
          F3_7: code = IC_BGEU;
          default: found = 1'b0;
        endcase
      end
      OPC_JALR: begin
        if (f3 == F3_0) code = IC_JALR;
        else found = 1'b0;
      end
      OPC_JAL:   code = IC_JAL;
      OPC_LUI:   code = IC_LUI;
      OPC_AUIPC: code = IC_AUIPC;
      default:   found = 1'b0;
    endcase
  end

  always_comb begin
    case (opc)
      OPC_OP, OPC_OP32: begin
        fmt = FMT_R;  ctl = CTL_R;
      end
      OPC_OPIMM, OPC_OPIMM32: begin
        fmt = FMT_I;  ctl = CTL_IARITH;
      end
      OPC_LOAD: begin
        fmt = FMT_I;  ctl = CTL_LOAD;
      end
      OPC_STORE: begin
        fmt = FMT_S;  ctl = CTL_STORE;
      end
      OPC_BRANCH: begin
        fmt = FMT_SB; ctl = CTL_BRANCH;
      end
      OPC_JALR: begin
        fmt = FMT_UJ; ctl = CTL_JALR;
      end
      OPC_JAL: begin
        fmt = FMT_UJ; ctl = CTL_JAL;
      end
      OPC_LUI: begin
        fmt = FMT_U;  ctl = CTL_LUI;
      end
      default: begin
        fmt = FMT_U;  ctl = CTL_AUIPC;
      end
    endcase
  end

  always_comb begin
    result.illegal       = !found;
    result.format        = FMT_R;
    result.instr_code    = IC_ADD;
    result.control_lines = CTL_NONE;
    result.immediate     = '0;
    result.dest_reg      = instr_word[11:7];
    result.src_reg_a     = instr_word[19:15];
    result.src_reg_b     = instr_word[24:20];
    if (found) begin
      result.format        = fmt;
      result.instr_code    = code;
      result.control_lines = ctl;
      if (fmt == FMT_I) begin
        result.immediate = instr_word[31:20];
      end else if (fmt == FMT_S) begin
        result.immediate = {instr_word[31:25], instr_word[11:7]};
      end
    end
  end

endmodule
`default_nettype wire

### hdl/rid_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rid_out_stage
// Result register: holds one decoded item until the consumer takes it and
// refills in the same cycle that it is emptied.
// ----------------------------------------------------------------------------
module rid_out_stage import rid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        stage_valid,
  output logic             stage_ready,
  input  wire rid_result_t stage_result,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rid_result_t      out_result
);

  logic        valid_r, valid_nxt;
  rid_result_t result_r;

  assign stage_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready) begin
      valid_nxt = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_ready) begin
      result_r <= stage_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire
